[rtl/serial_response_frame_decoder_unit_assert.svh]
// Assertion macros for the checker of the reply frame decoder.
// Needs nothing else; included by the checker module only.
`ifndef SERIAL_RESPONSE_FRAME_DECODER_UNIT_ASSERT_SVH
`define SERIAL_RESPONSE_FRAME_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRFD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("srfd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("srfd assertion failed");

`endif

[rtl/srfd_pkg.sv]
// Shared constants, status codes and the CRC-16 byte update of the reply frame decoder.
// Has no dependencies; used by the decoder and its checker.
package srfd_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 256;

  localparam logic [15:0] CRC_SEED  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  FUNC_CODE = 8'h40;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_CRC_BAD  = 3'd2,
    ST_BAD_FUNC = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_t;

  // Reflected CRC-16 over one byte, eight shift steps unrolled.
  function automatic logic [15:0] crc_byte_update(input logic [15:0] crc_in,
                                                  input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/serial_response_frame_decoder_unit.sv]
// Reply frame decoder: one received byte per transaction, emits payload words and a frame status.
// Depends on srfd_pkg for the CRC update, constants and status codes.
//
// The block takes one byte of a reply frame in every cycle unless the input is held off, and
// needs no gap between frames. The CRC-16 update of the previous byte (eight unrolled steps)
// and the word pairing sit between the state registers and an output register, so a result
// appears in the cycle after its byte is taken. A word is emitted for every second payload
// byte that is confirmed not to be a CRC byte and lies within the frame's byte count, and one
// status transaction closes every frame, carrying the number of words emitted. The input is
// held off only while a result waits in the output register and the consumer stalls.
module serial_response_frame_decoder_unit #(
  parameter int unsigned MAX_FRAME_BYTES = srfd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [15:0] out_word_value,
  output logic [6:0]  out_word_number,
  output logic [2:0]  out_status,
  output logic        out_last
);
  import srfd_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_FRAME_BYTES);

  logic [15:0]     crc_r, crc_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [15:0]     count_r, count_nxt;
  logic [7:0]      held_r, held_nxt;
  logic [7:0]      high_r, high_nxt;
  logic            func_ok_r, func_ok_nxt;
  logic [6:0]      word_cnt_r, word_cnt_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            kind_r;
  logic [15:0]     word_value_r;
  logic [6:0]      word_number_r;
  status_t         status_r;

  logic            in_acc;
  logic            res_valid;
  logic            res_kind;
  logic [15:0]     res_word;
  status_t         res_status;
  logic            func_ok_eff;
  logic [15:0]     crc_step;
  logic [15:0]     words_seen;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign crc_step = crc_byte_update(crc_r, held_r);
  // Payload bytes seen so far, counting the byte being committed (position minus eight).
  assign words_seen = 16'(pos_r - PosW'(8));

  always_comb begin
    crc_nxt      = crc_r;
    pos_nxt      = pos_r;
    count_nxt    = count_r;
    held_nxt     = held_r;
    high_nxt     = high_r;
    func_ok_nxt  = func_ok_r;
    word_cnt_nxt = word_cnt_r;
    res_valid    = 1'b0;
    res_kind     = 1'b0;
    res_word     = '0;
    res_status   = ST_OK;
    func_ok_eff  = func_ok_r;
    if (pos_r == PosW'(1)) begin
      func_ok_eff = (in_rx_byte == FUNC_CODE);
    end
    if (in_acc) begin
      if (pos_r == PosW'(6)) begin
        count_nxt = {in_rx_byte, count_r[7:0]};
      end
      if (pos_r == PosW'(7)) begin
        count_nxt = {count_r[15:8], in_rx_byte};
      end
      func_ok_nxt = func_ok_eff;
      if (in_frame_end) begin
        res_valid = 1'b1;
        res_kind  = 1'b1;
        if (pos_r == '0) begin
          res_status = ST_SHORT;
        end else if (pos_r >= PosMax) begin
          res_status = ST_TOO_LONG;
        end else if (crc_r != {in_rx_byte, held_r}) begin
          res_status = ST_CRC_BAD;
        end else if (!func_ok_eff) begin
          res_status = ST_BAD_FUNC;
        end else begin
          res_status = ST_OK;
        end
        crc_nxt      = CRC_SEED;
        pos_nxt      = '0;
        count_nxt    = '0;
        held_nxt     = '0;
        high_nxt     = '0;
        func_ok_nxt  = 1'b0;
        word_cnt_nxt = '0;
      end else begin
        // The held byte is followed by a non-final byte, so it cannot be a CRC byte.
        if (pos_r != '0 && pos_r < PosMax) begin
          crc_nxt = crc_step;
          if (pos_r >= PosW'(9)) begin
            if (pos_r[0]) begin
              high_nxt = held_r;
            end else if (words_seen <= count_r) begin
              res_valid    = 1'b1;
              res_word     = {high_r, held_r};
              word_cnt_nxt = word_cnt_r + 7'd1;
            end
          end
        end
        held_nxt = in_rx_byte;
        if (pos_r < PosMax) begin
          pos_nxt = pos_r + PosW'(1);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = res_valid;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_SEED;
      pos_r       <= '0;
      count_r     <= '0;
      held_r      <= '0;
      high_r      <= '0;
      func_ok_r   <= 1'b0;
      word_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      held_r      <= held_nxt;
      high_r      <= high_nxt;
      func_ok_r   <= func_ok_nxt;
      word_cnt_r  <= word_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      kind_r        <= res_kind;
      word_value_r  <= res_word;
      word_number_r <= word_cnt_r;
      status_r      <= res_status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_word_value  = word_value_r;
  assign out_word_number = word_number_r;
  assign out_status      = status_r;
  assign out_last        = kind_r;

endmodule

[rtl/srfd_checker.sv]
// Port-level checker for the reply frame decoder, attached by the bind at the end of the file.
// Depends on srfd_pkg and the assertion macro header.
`include "serial_response_frame_decoder_unit_assert.svh"

module srfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [15:0] out_word_value,
  input logic [6:0]  out_word_number,
  input logic [2:0]  out_status,
  input logic        out_last
);
  import srfd_pkg::*;

  // Input is held off only by a waiting result that the consumer stalls.
  `SRFD_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
  // A word transaction never carries the frame status or the last mark.
  `SRFD_ASSERT_IMPLY(a_word_shape, clk, rst_n, out_valid && !out_kind,
                     !out_last && out_status == ST_OK)
  // A status transaction is marked last, has no word value and a defined code.
  `SRFD_ASSERT_IMPLY(a_status_shape, clk, rst_n, out_valid && out_kind,
                     out_last && out_word_value == 16'h0000 && out_status <= ST_TOO_LONG)
  // A stalled result stays put.
  `SRFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                    out_valid && $stable(out_word_value) && $stable(out_word_number))

endmodule

bind serial_response_frame_decoder_unit srfd_checker u_srfd_checker (.*);

[verif/serial_response_frame_decoder_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for serial_response_frame_decoder_unit: a table of directed frames,
// frames at the length limit, then random reply frames and noise checked by a predictor.
// Depends on srfd_pkg and the decoder RTL.
module serial_response_frame_decoder_unit_test;
  import srfd_pkg::*;

  localparam int unsigned FRAME_LIMIT = MAX_FRAME_BYTES_DEF;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned CALM_ITEMS = 150;

  typedef struct packed {
    logic        kind;
    logic [15:0] word_value;
    logic [6:0]  word_number;
    status_t     status;
    logic        last;
  } reply_item_t;

  // Where a table byte comes from: typed in, or the CRC of the frame so far.
  typedef enum logic [1:0] {SRC_LIT, SRC_CRC_LO, SRC_CRC_HI} byte_src_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    byte_src_t  src;
    logic       typed;
    status_t    st;
    logic [6:0] wn;
  } table_row_t;

  localparam table_row_t DIRECTED_ROWS [25] = '{
    // One byte only.
    '{8'h00, 1'b1, SRC_LIT, 1'b1, ST_SHORT, 7'd0},
    // Two-byte frames: nothing is folded into the CRC, so it must read 0xFFFF.
    '{8'h00, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{8'h00, 1'b1, SRC_LIT, 1'b1, ST_CRC_BAD, 7'd0},
    '{8'h01, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{FUNC_CODE, 1'b1, SRC_LIT, 1'b1, ST_CRC_BAD, 7'd0},
    '{8'hFF, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{8'hFF, 1'b1, SRC_LIT, 1'b1, ST_BAD_FUNC, 7'd0},
    // Good frame with two payload words.
    '{8'h11, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{FUNC_CODE, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{8'h00, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{8'h00, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{8'h00, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{8'h00, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{8'h00, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{8'h04, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{8'hFF, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{8'h00, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{8'h00, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{8'hFF, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{8'h00, 1'b0, SRC_CRC_LO, 1'b0, ST_OK, 7'd0},
    '{8'h00, 1'b1, SRC_CRC_HI, 1'b1, ST_OK, 7'd2},
    // Correct CRC but the wrong function code.
    '{8'h11, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{8'h41, 1'b0, SRC_LIT, 1'b0, ST_OK, 7'd0},
    '{8'h00, 1'b0, SRC_CRC_LO, 1'b0, ST_OK, 7'd0},
    '{8'h00, 1'b1, SRC_CRC_HI, 1'b1, ST_BAD_FUNC, 7'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        in_frame_end;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [15:0] out_word_value;
  logic [6:0]  out_word_number;
  logic [2:0]  out_status;
  logic        out_last;

  // Predictor copy of the decoder state.
  logic [15:0] crc_run;
  int unsigned byte_pos;
  logic [15:0] pay_count;
  logic [7:0]  held_lo;
  logic [7:0]  hi_pending;
  bit          func_ok;
  logic [6:0]  word_idx;

  reply_item_t expected_q[$];
  logic [7:0]  frame_q[$];
  int          err_count = 0;
  int          items_sent = 0;
  int          sender_quiet = 0;
  bit          calm = 1'b0;

  serial_response_frame_decoder_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_word_value  (out_word_value),
    .out_word_number (out_word_number),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic void add_frame_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  function automatic void add_expected(input reply_item_t item);
    expected_q.insert(expected_q.size(), item);
  endfunction

  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] v;
    v = acc ^ {8'h00, b};
    repeat (8) v = v[0] ? ({1'b0, v[15:1]} ^ CRC_POLY) : {1'b0, v[15:1]};
    return v;
  endfunction

  function automatic void clear_decoder_state();
    crc_run = CRC_SEED;
    byte_pos = 0;
    pay_count = '0;
    held_lo = '0;
    hi_pending = '0;
    func_ok = 1'b0;
    word_idx = '0;
  endfunction

  // Advances the predicted state by one byte; returns 1 when the byte yields a transaction.
  function automatic bit predict_byte(input logic [7:0] b, input logic fin,
                                      output reply_item_t r);
    int unsigned p;
    int unsigned k;
    bit hit;
    p = byte_pos;
    r = '0;
    hit = 1'b0;
    if (p == 1) func_ok = (b == FUNC_CODE);
    if (p == 6) pay_count[15:8] = b;
    if (p == 7) pay_count[7:0] = b;
    if (fin) begin
      r.kind = 1'b1;
      r.last = 1'b1;
      r.word_number = word_idx;
      if (p == 0) r.status = ST_SHORT;
      else if (p >= FRAME_LIMIT) r.status = ST_TOO_LONG;
      else if (crc_run != {b, held_lo}) r.status = ST_CRC_BAD;
      else if (!func_ok) r.status = ST_BAD_FUNC;
      else r.status = ST_OK;
      clear_decoder_state();
      return 1'b1;
    end
    // The held byte is now known not to be a CRC byte, so it joins the CRC and the payload.
    if (p >= 1 && p < FRAME_LIMIT) begin
      crc_run = crc16_fold(crc_run, held_lo);
      if (p - 1 >= 8) begin
        k = p - 9;
        if (k % 2 == 0) begin
          hi_pending = held_lo;
        end else if (k + 1 <= pay_count) begin
          r.kind = 1'b0;
          r.word_value = {hi_pending, held_lo};
          r.word_number = word_idx;
          r.status = ST_OK;
          r.last = 1'b0;
          word_idx++;
          hit = 1'b1;
        end
      end
    end
    held_lo = b;
    if (byte_pos < FRAME_LIMIT) byte_pos++;
    return hit;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin, input bit typed,
                           input reply_item_t typed_exp);
    reply_item_t r;
    int gap;
    if (!calm && sender_quiet == 0 && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      sender_quiet = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : 0;
    end else if (sender_quiet > 0) begin
      sender_quiet--;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_frame_end <= fin;
    do @(posedge clk); while (in_stall);
    if (predict_byte(b, fin, r)) add_expected(typed ? typed_exp : r);
    else if (typed) report_mismatch("directed row expects a transaction that cannot occur");
    items_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
  endtask

  // Builds a reply frame; a clean one has the right function code, count and CRC.
  task automatic build_reply(input int pay_len, input bit clean);
    logic [15:0] crc;
    logic [15:0] cnt;
    frame_q.delete();
    add_frame_byte(8'($urandom_range(0, 255)));
    if (!clean && $urandom_range(0, 14) == 0) add_frame_byte(8'($urandom_range(0, 255)));
    else add_frame_byte(FUNC_CODE);
    repeat (4) add_frame_byte(8'($urandom_range(0, 255)));
    cnt = 16'(pay_len);
    if (!clean) begin
      case ($urandom_range(0, 9))
        6: cnt = 16'(pay_len + $urandom_range(1, 3));
        7: cnt = 16'($urandom_range(0, pay_len));
        8: cnt = 16'hFFFF;
        9: cnt = 16'($urandom_range(0, 65535));
        default: cnt = 16'(pay_len);
      endcase
    end
    add_frame_byte(cnt[15:8]);
    add_frame_byte(cnt[7:0]);
    repeat (pay_len) add_frame_byte(8'($urandom_range(0, 255)));
    crc = CRC_SEED;
    foreach (frame_q[i]) crc = crc16_fold(crc, frame_q[i]);
    if (!clean && $urandom_range(0, 9) == 0) crc ^= 16'(1 << $urandom_range(0, 15));
    add_frame_byte(crc[7:0]);
    add_frame_byte(crc[15:8]);
  endtask

  initial begin : stall_results
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
        // Sometimes follow a burst with a long stretch of free flow.
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(20, 60)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    reply_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("transaction with nothing expected: kind %0d value %h",
                                  out_kind, out_word_value));
      end else begin
        e = expected_q.pop_front();
        if (out_kind !== e.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_kind, e.kind));
        if (out_word_value !== e.word_value)
          report_mismatch($sformatf("word_value %h, expected %h", out_word_value, e.word_value));
        if (out_word_number !== e.word_number)
          report_mismatch($sformatf("word_number %0d, expected %0d", out_word_number,
                                    e.word_number));
        if (out_status !== e.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, e.status));
        if (out_last !== e.last)
          report_mismatch($sformatf("last %0d, expected %0d", out_last, e.last));
      end
    end
  end

  initial begin : stimulus
    reply_item_t typed_exp;
    logic [15:0] tbl_crc;
    logic [7:0]  b;
    int          start_items;
    int          pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    in_frame_end = 1'b0;
    clear_decoder_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tbl_crc = CRC_SEED;
    foreach (DIRECTED_ROWS[i]) begin
      case (DIRECTED_ROWS[i].src)
        SRC_CRC_LO: b = tbl_crc[7:0];
        SRC_CRC_HI: b = tbl_crc[15:8];
        default:    b = DIRECTED_ROWS[i].data;
      endcase
      typed_exp = '{kind: 1'b1, word_value: 16'h0000, word_number: DIRECTED_ROWS[i].wn,
                    status: DIRECTED_ROWS[i].st, last: 1'b1};
      send_byte(b, DIRECTED_ROWS[i].fin, DIRECTED_ROWS[i].typed, typed_exp);
      if (DIRECTED_ROWS[i].fin) tbl_crc = CRC_SEED;
      else if (DIRECTED_ROWS[i].src == SRC_LIT) tbl_crc = crc16_fold(tbl_crc, b);
    end

    // Let the decoder drain completely before the long frames.
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);

    // Frame lengths just under, at and just over the limit.
    for (int len = FRAME_LIMIT - 1; len <= FRAME_LIMIT + 1; len++) begin
      build_reply(len - 10, 1'b1);
      send_frame();
    end

    start_items = items_sent;
    while (items_sent < start_items + RANDOM_ITEMS) begin
      calm = (items_sent >= start_items + RANDOM_ITEMS - CALM_ITEMS);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // Noise and truncated frames.
        frame_q.delete();
        repeat ($urandom_range(1, 12)) add_frame_byte(8'($urandom_range(0, 255)));
      end else if (pick < 17) begin
        build_reply($urandom_range(180, 250), 1'b0);
      end else begin
        build_reply($urandom_range(0, 24), 1'b0);
      end
      send_frame();
    end
    calm = 1'b1;
    @(negedge clk);
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/srfd_pkg.sv
rtl/serial_response_frame_decoder_unit.sv
rtl/srfd_checker.sv
verif/serial_response_frame_decoder_unit_test.sv
